>>> design/bsmp_pkg.sv
// Shared constants, types and field layout for the bilinear remap sampler.
`default_nettype none

package bsmp_pkg;

    // Coordinate and fraction widths
    localparam int ROW_BITS  = 10;
    localparam int COL_BITS  = 11;
    localparam int FRAC_BITS = 8;

    // Pixel format
    localparam int PIX_W   = 8;
    localparam int NUM_CH  = 3;
    localparam int PIX_MAX = 255;

    // Input tdata layout, lowest bit first
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + ROW_BITS;
    localparam int RFRAC_LSB  = COL_LSB + COL_BITS;
    localparam int CFRAC_LSB  = RFRAC_LSB + FRAC_BITS;
    localparam int PIX_LSB    = CFRAC_LSB + FRAC_BITS;
    localparam int IN_FIELD_W = PIX_LSB + NUM_CH * PIX_W;
    localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int OUT_FIELD_W = NUM_CH * PIX_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // Frame store: four banks split by row and column parity
    localparam int NUM_BANKS  = 4;
    localparam int BANK_AW    = ROW_BITS + COL_BITS - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int STORE_W    = NUM_CH * PIX_W;

    // Blend arithmetic
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int PROD_W = WGT_W + PIX_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [FRAC_BITS:0] FRAC_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0]   ROUND_C   = SUM_W'(1) << (2 * FRAC_BITS - 1);

    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_SAMPLE = 1'b1
    } mode_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Neighborhood order: 0 = p00, 1 = p01, 2 = p10, 3 = p11
    typedef logic [NUM_BANKS-1:0][WGT_W-1:0] wgt_vec_t;
    typedef logic [NUM_BANKS-1:0][PIX_W-1:0] pix_vec_t;
    typedef logic [NUM_CH-1:0][PIX_W-1:0]    ch_vec_t;

    // Per-stage sideband of a sample in flight
    typedef struct packed {
        logic vld;
        logic oor;
    } sample_tag_t;

endpackage

`default_nettype wire

>>> design/bsmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsmp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/bsmp_lane.sv
// One channel lane: four weighted products, then sum, round and clamp.
`default_nettype none

module bsmp_lane
    import bsmp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     en,
    input  wire wgt_vec_t wgt,
    input  wire pix_vec_t pix,
    output pix_t          result
);

    logic [NUM_BANKS-1:0][PROD_W-1:0] prod_reg;
    logic [NUM_BANKS-1:0][PROD_W-1:0] prod_next;
    logic [SUM_W-1:0]                 sum;
    logic [SUM_W-1:0]                 quot;
    pix_t                             result_reg;
    pix_t                             result_next;

    always_comb
    begin
        for (int k = 0; k < NUM_BANKS; k++)
        begin
            prod_next[k] = PROD_W'(wgt[k]) * PROD_W'(pix[k]);
        end
    end

    // Round half up, then clamp to the pixel range
    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
            + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]) + ROUND_C;
        quot = sum >> (2 * FRAC_BITS);
        if (quot > SUM_W'(PIX_MAX))
        begin
            result_next = PIX_W'(PIX_MAX);
        end
        else
        begin
            result_next = quot[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> design/bsmp_merge.sv
// Merge stage: gathers lane results, applies range and channel masking.
`default_nettype none

module bsmp_merge
    import bsmp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire sample_tag_t           tag,
    input  wire logic                  single_channel,
    input  wire ch_vec_t               lane_pix,
    output logic                       out_valid,
    output logic [OUT_DATA_W-1:0]      out_data,
    output logic                       out_oor
);

    logic                   vld_reg;
    logic                   vld_next;
    logic [OUT_DATA_W-1:0]  data_reg;
    logic [OUT_DATA_W-1:0]  data_next;
    logic                   oor_reg;

    always_comb
    begin
        data_next = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (!tag.oor && (ch == 0 || !single_channel))
            begin
                data_next[ch*PIX_W +: PIX_W] = lane_pix[ch];
            end
        end
        vld_next = tag.vld;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            oor_reg  <= tag.oor;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;
    assign out_oor   = oor_reg;

endmodule

`default_nettype wire

>>> design/bilinear_remap_sampler_unit.sv
// Top level of the bilinear remap sampler: frame store, weights, lanes, merge.
`default_nettype none

// Channel   Dir  Fields (lowest bit first)
// --------  ---  --------------------------------------------------------------
// s_axis    in   tuser: mode; tdata: row, col, row_frac, col_frac, red, green,
//                blue, zero pad
// m_axis    out  tuser: out_of_range; tdata: out_red, out_green, out_blue
// cfg       in   cfg_we / cfg_wdata: single_channel
//
// One transaction per cycle sustained while m_axis is not stalled. A sample
// passes four registers (bank read plus weights, loaded at the accepting edge;
// products; sum/round; merge) and is valid on m_axis from the merge register.
// Writes produce nothing and go straight into one of four parity banks, one
// read port each. A stall on m_axis freezes the whole pipeline, memory read
// register included, and drops s_axis_tready the same cycle. Reset clears
// stage valids and single_channel; the frame store is not cleared.

module bilinear_remap_sampler_unit
    import bsmp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,      // single_channel
    // Input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // row, col, row_frac, col_frac,
                                                       // red, green, blue
    input  wire logic                  s_axis_tuser,   // mode
    // Output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // out_red, out_green, out_blue
    output logic                       m_axis_tuser    // out_of_range
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic single_channel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_channel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            single_channel_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: move whenever the output slot is free or draining
    // ------------------------------------------------------------------
    logic en;
    logic acc;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid && en;

    // ------------------------------------------------------------------
    // Field unpack
    // ------------------------------------------------------------------
    mode_t                 in_mode;
    logic [ROW_BITS-1:0]   in_row;
    logic [COL_BITS-1:0]   in_col;
    logic [FRAC_BITS-1:0]  in_u;
    logic [FRAC_BITS-1:0]  in_v;
    logic [STORE_W-1:0]    in_pix;

    assign in_mode = mode_t'(s_axis_tuser);
    assign in_row  = s_axis_tdata[ROW_LSB   +: ROW_BITS];
    assign in_col  = s_axis_tdata[COL_LSB   +: COL_BITS];
    assign in_u    = s_axis_tdata[RFRAC_LSB +: FRAC_BITS];
    assign in_v    = s_axis_tdata[CFRAC_LSB +: FRAC_BITS];
    assign in_pix  = s_axis_tdata[PIX_LSB   +: STORE_W];

    // ------------------------------------------------------------------
    // Bank addressing. Bank index is {row parity, col parity}; within a
    // bank the address is {row >> 1, col >> 1}. Of rows r-1 and r, exactly
    // one has each parity, same for columns, so each bank serves one tap.
    // ------------------------------------------------------------------
    logic [ROW_BITS-1:0]                row_m1;
    logic [COL_BITS-1:0]                col_m1;
    logic [BANK_AW-1:0]                 waddr;
    logic [NUM_BANKS-1:0]               bank_we;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]  bank_raddr;
    logic [NUM_BANKS-1:0][STORE_W-1:0]  bank_rdata;

    assign row_m1 = in_row - ROW_BITS'(1);
    assign col_m1 = in_col - COL_BITS'(1);
    assign waddr  = {in_row[ROW_BITS-1:1], in_col[COL_BITS-1:1]};

    always_comb
    begin
        logic [ROW_BITS-1:0] row_sel;
        logic [COL_BITS-1:0] col_sel;
        logic [1:0]          bidx;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bidx       = 2'(b);
            row_sel    = (in_row[0] == bidx[1]) ? in_row : row_m1;
            col_sel    = (in_col[0] == bidx[0]) ? in_col : col_m1;
            bank_raddr[b] = {row_sel[ROW_BITS-1:1], col_sel[COL_BITS-1:1]};
            bank_we[b] = acc && (in_mode == MODE_WRITE)
                         && ({in_row[0], in_col[0]} == bidx);
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        bsmp_ram #(
            .WIDTH (STORE_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (waddr),
            .wdata (in_pix),
            .re    (en),
            .raddr (bank_raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    // ------------------------------------------------------------------
    // Bilinear weights, computed alongside the bank read
    //   w00 = (F-u)(F-v), w01 = (F-u)v, w10 = u(F-v), w11 = uv
    // ------------------------------------------------------------------
    logic [FRAC_BITS:0]       fu;
    logic [FRAC_BITS:0]       fv;
    logic [FRAC_BITS:0]       ue;
    logic [FRAC_BITS:0]       ve;
    logic [2*FRAC_BITS+1:0]   wp00;
    logic [2*FRAC_BITS+1:0]   wp01;
    logic [2*FRAC_BITS+1:0]   wp10;
    logic [2*FRAC_BITS+1:0]   wp11;
    wgt_vec_t                 wgt_next;

    assign ue   = {1'b0, in_u};
    assign ve   = {1'b0, in_v};
    assign fu   = FRAC_ONE - ue;
    assign fv   = FRAC_ONE - ve;
    assign wp00 = (2*FRAC_BITS+2)'(fu) * (2*FRAC_BITS+2)'(fv);
    assign wp01 = (2*FRAC_BITS+2)'(fu) * (2*FRAC_BITS+2)'(ve);
    assign wp10 = (2*FRAC_BITS+2)'(ue) * (2*FRAC_BITS+2)'(fv);
    assign wp11 = (2*FRAC_BITS+2)'(ue) * (2*FRAC_BITS+2)'(ve);

    assign wgt_next[0] = wp00[WGT_W-1:0];
    assign wgt_next[1] = wp01[WGT_W-1:0];
    assign wgt_next[2] = wp10[WGT_W-1:0];
    assign wgt_next[3] = wp11[WGT_W-1:0];

    // ------------------------------------------------------------------
    // Stage 1 (lines up with the bank read data)
    // ------------------------------------------------------------------
    sample_tag_t tag1_reg;
    sample_tag_t tag1_next;
    sample_tag_t tag2_reg;
    sample_tag_t tag3_reg;
    wgt_vec_t    wgt1_reg;
    logic        r0_1_reg;
    logic        c0_1_reg;

    always_comb
    begin
        tag1_next.vld = acc && (in_mode == MODE_SAMPLE);
        tag1_next.oor = (in_row == '0) || (in_col == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wgt1_reg <= wgt_next;
            r0_1_reg <= in_row[0];
            c0_1_reg <= in_col[0];
        end
    end

    // Route bank outputs to taps: p11 sits in bank {r0, c0}; stepping back
    // a row or column flips the matching parity bit.
    pix_vec_t [NUM_CH-1:0] lane_pix;

    always_comb
    begin
        logic [1:0] kidx;
        logic [1:0] bsel;
        for (int k = 0; k < NUM_BANKS; k++)
        begin
            kidx = 2'(k);
            bsel = {r0_1_reg ^ ~kidx[1], c0_1_reg ^ ~kidx[0]};
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                lane_pix[ch][k] = bank_rdata[bsel][ch*PIX_W +: PIX_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel lanes (stages 2 and 3)
    // ------------------------------------------------------------------
    ch_vec_t lane_result;

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        bsmp_lane u_lane (
            .clk    (clk),
            .en     (en),
            .wgt    (wgt1_reg),
            .pix    (lane_pix[ch]),
            .result (lane_result[ch])
        );
    end

    // ------------------------------------------------------------------
    // Merge and output register (stage 4)
    // ------------------------------------------------------------------
    bsmp_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .tag            (tag3_reg),
        .single_channel (single_channel_reg),
        .lane_pix       (lane_result),
        .out_valid      (m_axis_tvalid),
        .out_data       (m_axis_tdata),
        .out_oor        (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> bench/remap_sb_pkg.sv
// Transaction types and scoreboard for the bilinear remap sampler bench.
package remap_sb_pkg;
    import bsmp_pkg::*;

    typedef struct {
        mode_t                mode;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic [FRAC_BITS-1:0] row_frac;
        logic [FRAC_BITS-1:0] col_frac;
        pix_t                 red;
        pix_t                 green;
        pix_t                 blue;
    } remap_req_t;

    typedef struct {
        pix_t red;
        pix_t green;
        pix_t blue;
        logic oor;
    } remap_px_t;

    class remap_scoreboard;
        logic [STORE_W-1:0] pixel_at [int unsigned];  // shadow frame store
        bit                 mono;                     // single_channel
        remap_px_t          expected_px [$];
        int                 errors;

        function int unsigned store_key(int unsigned r, int unsigned c);
            return (r << COL_BITS) | c;
        endfunction

        // Weighted 2x2 sum, round half up, clamp
        function pix_t blend_channel(int unsigned p00, int unsigned p01,
                                     int unsigned p10, int unsigned p11,
                                     int unsigned u, int unsigned v);
            int unsigned one;
            int unsigned acc;
            one = 1 << FRAC_BITS;
            acc = (one - u) * (one - v) * p00 + (one - u) * v * p01
                + u * (one - v) * p10 + u * v * p11;
            acc = (acc + (1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
            if (acc > PIX_MAX)
                acc = PIX_MAX;
            return pix_t'(acc);
        endfunction

        function void set_single_channel(bit v);
            mono = v;
        endfunction

        function void note_request(remap_req_t rq);
            remap_px_t          px;
            logic [STORE_W-1:0] nb [4];
            pix_t               lane [NUM_CH];
            int unsigned        r;
            int unsigned        c;
            r = 32'(rq.row);
            c = 32'(rq.col);
            if (rq.mode == MODE_WRITE) begin
                pixel_at[store_key(r, c)] = {rq.blue, rq.green, rq.red};
                return;
            end
            foreach (lane[ch])
                lane[ch] = '0;
            px.oor = (r == 0 || c == 0);
            if (!px.oor) begin
                nb[0] = pixel_at[store_key(r - 1, c - 1)];
                nb[1] = pixel_at[store_key(r - 1, c)];
                nb[2] = pixel_at[store_key(r, c - 1)];
                nb[3] = pixel_at[store_key(r, c)];
                for (int ch = 0; ch < (mono ? 1 : NUM_CH); ch++)
                    lane[ch] = blend_channel(32'(nb[0][PIX_W*ch +: PIX_W]),
                                             32'(nb[1][PIX_W*ch +: PIX_W]),
                                             32'(nb[2][PIX_W*ch +: PIX_W]),
                                             32'(nb[3][PIX_W*ch +: PIX_W]),
                                             32'(rq.row_frac), 32'(rq.col_frac));
            end
            px.red   = lane[0];
            px.green = lane[1];
            px.blue  = lane[2];
            expected_px.push_back(px);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t: %s", $time, what);
        endtask

        task check_pixel(remap_px_t got);
            remap_px_t want;
            if (expected_px.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d oor=%0b",
                                          got.red, got.green, got.blue, got.oor));
                return;
            end
            want = expected_px.pop_front();
            if (got.red !== want.red || got.green !== want.green
                || got.blue !== want.blue || got.oor !== want.oor)
                report_mismatch($sformatf(
                    "pixel r=%0d g=%0d b=%0d oor=%0b, want r=%0d g=%0d b=%0d oor=%0b",
                    got.red, got.green, got.blue, got.oor,
                    want.red, want.green, want.blue, want.oor));
        endtask

        function int pending();
            return expected_px.size();
        endfunction
    endclass

endpackage

>>> bench/tb_bilinear_remap_sampler_unit.sv
// Top-level bench for the bilinear remap sampler: stimulus, handshakes, checking.
module tb_bilinear_remap_sampler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bsmp_pkg::*;
    import remap_sb_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;  // far beyond the slowest legal run
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 456;
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int MAX_ANCHORS  = 64;

    // Coordinate whose full 2x2 neighborhood has been written
    typedef struct {
        int unsigned row;
        int unsigned col;
    } anchor_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic                  cfg_wdata     = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // row, col, row_frac, col_frac, red, green, blue
    logic                  s_axis_tuser  = 1'b0; // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // out_red, out_green, out_blue
    logic                  m_axis_tuser;         // out_of_range

    remap_scoreboard sb = new();
    anchor_t         anchors [$];
    int              tx_idle_pct  = 0;
    int              rx_stall_pct = 0;
    int              hold_len     = 0;
    int              items_sent   = 0;
    int              cycle_count  = 0;

    bilinear_remap_sampler_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus an occasional long hold-off that
    // lets the pipeline fill and forces s_axis_tready low.
    initial
    begin
        int stretch;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                stretch = hold_len;
                hold_len <= 0;
                m_axis_tready <= 1'b0;
                repeat (stretch) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor. Inputs only change at the rising edge, so the values seen at
    // the falling edge are exactly what the next rising edge accepts.
    always @(negedge clk)
    begin
        remap_px_t  got;
        remap_req_t rq;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.red   = m_axis_tdata[0 +: PIX_W];
                got.green = m_axis_tdata[PIX_W +: PIX_W];
                got.blue  = m_axis_tdata[2*PIX_W +: PIX_W];
                got.oor   = m_axis_tuser;
                sb.check_pixel(got);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                rq.mode     = mode_t'(s_axis_tuser);
                rq.row      = s_axis_tdata[ROW_LSB +: ROW_BITS];
                rq.col      = s_axis_tdata[COL_LSB +: COL_BITS];
                rq.row_frac = s_axis_tdata[RFRAC_LSB +: FRAC_BITS];
                rq.col_frac = s_axis_tdata[CFRAC_LSB +: FRAC_BITS];
                rq.red      = s_axis_tdata[PIX_LSB +: PIX_W];
                rq.green    = s_axis_tdata[PIX_LSB + PIX_W +: PIX_W];
                rq.blue     = s_axis_tdata[PIX_LSB + 2*PIX_W +: PIX_W];
                sb.note_request(rq);
            end
        end
    end

    // Pixel values lean toward the extremes now and then
    function automatic pix_t rand_pix();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return pix_t'($urandom_range(PIX_MAX));
    endfunction

    // Write transaction; fraction fields are don't-care and randomized
    function automatic remap_req_t make_write(int unsigned row, int unsigned col,
                                              pix_t red, pix_t green, pix_t blue);
        remap_req_t rq;
        rq.mode     = MODE_WRITE;
        rq.row      = row[ROW_BITS-1:0];
        rq.col      = col[COL_BITS-1:0];
        rq.row_frac = FRAC_BITS'($urandom_range((1 << FRAC_BITS) - 1));
        rq.col_frac = FRAC_BITS'($urandom_range((1 << FRAC_BITS) - 1));
        rq.red      = red;
        rq.green    = green;
        rq.blue     = blue;
        return rq;
    endfunction

    // Sample transaction; pixel fields are don't-care and randomized
    function automatic remap_req_t make_sample(int unsigned row, int unsigned col,
                                               int unsigned u, int unsigned v);
        remap_req_t rq;
        rq.mode     = MODE_SAMPLE;
        rq.row      = row[ROW_BITS-1:0];
        rq.col      = col[COL_BITS-1:0];
        rq.row_frac = u[FRAC_BITS-1:0];
        rq.col_frac = v[FRAC_BITS-1:0];
        rq.red      = pix_t'($urandom);
        rq.green    = pix_t'($urandom);
        rq.blue     = pix_t'($urandom);
        return rq;
    endfunction

    function automatic int unsigned rand_frac();
        return $urandom_range((1 << FRAC_BITS) - 1);
    endfunction

    // Offer one transaction, with a random gap first, and hold it until taken
    task automatic send_req(input remap_req_t rq);
        logic [IN_DATA_W-1:0] word;
        logic                 rdy;
        word = '0;
        word[ROW_LSB +: ROW_BITS]             = rq.row;
        word[COL_LSB +: COL_BITS]             = rq.col;
        word[RFRAC_LSB +: FRAC_BITS]          = rq.row_frac;
        word[CFRAC_LSB +: FRAC_BITS]          = rq.col_frac;
        word[PIX_LSB +: PIX_W]                = rq.red;
        word[PIX_LSB + PIX_W +: PIX_W]        = rq.green;
        word[PIX_LSB + 2*PIX_W +: PIX_W]      = rq.blue;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= rq.mode;
        do
        begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end
        while (!rdy);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Register writes only once the pipeline is empty
    task automatic load_single_channel(input bit v);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_single_channel(v);
    endtask

    // Random traffic. Most of it builds fully written neighborhoods and
    // samples them; the rest is out-of-range samples, stray writes and
    // write-then-sample hazards on a live neighborhood.
    task automatic run_phase(input int tx_idle, input int rx_stall, input int n_items);
        int      first;
        int      pick;
        int      k;
        int      kind;
        anchor_t a;
        first        = items_sent;
        tx_idle_pct  = tx_idle;
        rx_stall_pct <= rx_stall;
        while (items_sent - first < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                a.row = $urandom_range((1 << ROW_BITS) - 1, 1);
                a.col = $urandom_range((1 << COL_BITS) - 1, 1);
                k = $urandom_range(3);
                for (int i = 0; i < 4; i++)
                    send_req(make_write(a.row - 1 + ((k + i) % 4) / 2,
                                        a.col - 1 + ((k + i) % 4) % 2,
                                        rand_pix(), rand_pix(), rand_pix()));
                anchors.push_back(a);
                if (anchors.size() > MAX_ANCHORS)
                    void'(anchors.pop_front());
                repeat ($urandom_range(4, 1))
                    send_req(make_sample(a.row, a.col, rand_frac(), rand_frac()));
            end
            else if (pick < 72)
            begin
                a = anchors[$urandom_range(anchors.size() - 1)];
                repeat ($urandom_range(3, 1))
                    send_req(make_sample(a.row, a.col, rand_frac(), rand_frac()));
            end
            else if (pick < 84)
            begin
                // no neighborhood above or left: flagged, all channels zero
                a.row = $urandom_range((1 << ROW_BITS) - 1);
                a.col = $urandom_range((1 << COL_BITS) - 1);
                kind  = $urandom_range(2);
                if (kind != 1)
                    a.row = 0;
                if (kind != 0)
                    a.col = 0;
                send_req(make_sample(a.row, a.col, rand_frac(), rand_frac()));
            end
            else if (pick < 94)
                send_req(make_write($urandom_range((1 << ROW_BITS) - 1),
                                    $urandom_range((1 << COL_BITS) - 1),
                                    rand_pix(), rand_pix(), rand_pix()));
            else
            begin
                // overwrite one neighbor and sample right behind it
                a = anchors[$urandom_range(anchors.size() - 1)];
                k = $urandom_range(3);
                send_req(make_write(a.row - 1 + k / 2, a.col - 1 + k % 2,
                                    rand_pix(), rand_pix(), rand_pix()));
                send_req(make_sample(a.row, a.col, rand_frac(), rand_frac()));
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        anchor_t a;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, single_channel at its reset value.
        // Corner anchor at (1,1): mixed extreme pixels, corner fractions.
        send_req(make_write(0, 0, 8'd255, 8'd255, 8'd255));
        send_req(make_write(0, 1, 8'd0, 8'd0, 8'd0));
        send_req(make_write(1, 0, 8'd255, 8'd0, 8'd128));
        send_req(make_write(1, 1, 8'd0, 8'd255, 8'd1));
        send_req(make_sample(1, 1, 0, 0));
        send_req(make_sample(1, 1, 255, 255));
        send_req(make_sample(1, 1, 0, 255));
        send_req(make_sample(1, 1, 255, 0));
        send_req(make_sample(1, 1, 128, 128));
        // Far corner, all full scale: exercises the top of the range
        send_req(make_write(1022, 2046, 8'd255, 8'd255, 8'd255));
        send_req(make_write(1022, 2047, 8'd255, 8'd255, 8'd255));
        send_req(make_write(1023, 2046, 8'd255, 8'd255, 8'd255));
        send_req(make_write(1023, 2047, 8'd255, 8'd255, 8'd255));
        send_req(make_sample(1023, 2047, 255, 255));
        send_req(make_sample(1023, 2047, 0, 0));
        // Exact half-way sums must round up to 1
        send_req(make_write(4, 8, 8'd1, 8'd1, 8'd1));
        send_req(make_write(4, 9, 8'd0, 8'd0, 8'd0));
        send_req(make_write(5, 8, 8'd0, 8'd0, 8'd0));
        send_req(make_write(5, 9, 8'd0, 8'd0, 8'd0));
        send_req(make_sample(5, 9, 128, 0));
        send_req(make_sample(5, 9, 0, 128));
        // Zero row and/or column: out of range
        send_req(make_sample(0, 0, rand_frac(), rand_frac()));
        send_req(make_sample(0, 2047, rand_frac(), rand_frac()));
        send_req(make_sample(1023, 0, rand_frac(), rand_frac()));
        send_req(make_sample(7, 0, rand_frac(), rand_frac()));
        a.row = 1;    a.col = 1;    anchors.push_back(a);
        a.row = 1023; a.col = 2047; anchors.push_back(a);
        a.row = 5;    a.col = 9;    anchors.push_back(a);

        // Random part: four idling profiles, single_channel toggled between
        run_phase(0, 0, PHASE_ITEMS);
        load_single_channel(1'b1);
        run_phase(56, 0, PHASE_ITEMS);
        load_single_channel(1'b0);
        run_phase(0, 56, PHASE_ITEMS);
        load_single_channel(1'b1);
        hold_len <= HOLD_CYCLES;  // receiver blocks while the sender keeps pushing
        run_phase(7, 7, PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
